// ===== rtl/lob_pkg.sv =====
`timescale 1ns / 1ps

package lob_pkg;

    localparam int ORDER_SLOTS = 256;
    localparam int SLOT_W      = $clog2(ORDER_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int QTY_W       = 32;
    localparam int PRICE_W     = 32;
    localparam int KEY_W       = 32;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_MODIFY = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_TRADE  = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_BEST,
        S_TAKE,
        S_TOP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   qty;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic              set_valid;
        logic              clr_valid;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } store_ctl_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } store_rd_t;

    function automatic logic [QTY_W-1:0] sat_add(input logic [QTY_W-1:0] a,
                                                 input logic [QTY_W-1:0] b);
        logic [QTY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[QTY_W] ? {QTY_W{1'b1}} : s[QTY_W-1:0];
    endfunction

endpackage

// ===== rtl/lob_if.sv =====
`timescale 1ns / 1ps

interface lob_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic        side;
    logic [31:0] price;
    logic [31:0] order_key;
    logic [31:0] quantity;

    modport source (output valid, command, side, price, order_key, quantity, input ready);
    modport sink (input valid, command, side, price, order_key, quantity, output ready);
endinterface

interface lob_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        filled_qty;
    logic               bid_present;
    logic [31:0]        best_bid_price;
    logic [31:0]        best_bid_qty;
    logic               ask_present;
    logic [31:0]        best_ask_price;
    logic [31:0]        best_ask_qty;
    logic [31:0]        midpoint;
    logic signed [32:0] spread;

    modport source (output valid, status, filled_qty, bid_present, best_bid_price,
                    best_bid_qty, ask_present, best_ask_price, best_ask_qty,
                    midpoint, spread, input ready);
    modport sink (input valid, status, filled_qty, bid_present, best_bid_price,
                  best_bid_qty, ask_present, best_ask_price, best_ask_qty,
                  midpoint, spread, output ready);
endinterface

// ===== rtl/lob_store.sv =====
`timescale 1ns / 1ps

module lob_store (
    input  logic                clk,
    input  logic                rst_n,
    input  lob_pkg::store_ctl_t ctl,
    output lob_pkg::store_rd_t  rd
);
    import lob_pkg::*;

    entry_t                 mem [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] valid_reg;
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data_reg <= mem[ctl.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.set_valid)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.clr_valid)
            begin
                valid_reg[ctl.wr_addr] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[ctl.rd_addr];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.data  = rd_data_reg;

endmodule

// ===== rtl/lob_ctrl.sv =====
`timescale 1ns / 1ps

module lob_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    lob_req_if.sink             req,
    lob_rsp_if.source           rsp,
    output lob_pkg::store_ctl_t ctl,
    input  lob_pkg::store_rd_t  rd
);
    import lob_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [2:0]         cmd_reg, cmd_next;
    logic               side_reg, side_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;
    logic [QTY_W-1:0]   remaining_reg, remaining_next;
    status_t            status_reg, status_next;

    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_idx_reg, hit_idx_next;
    logic [QTY_W-1:0]  hit_qty_reg, hit_qty_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;

    logic               best_found_reg, best_found_next;
    logic [SLOT_W-1:0]  best_idx_reg, best_idx_next;
    logic [PRICE_W-1:0] best_price_reg, best_price_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    logic [QTY_W-1:0]   best_qty_reg, best_qty_next;

    logic               bid_found_reg, bid_found_next;
    logic [PRICE_W-1:0] bid_price_reg, bid_price_next;
    logic [QTY_W-1:0]   bid_qty_reg, bid_qty_next;
    logic               ask_found_reg, ask_found_next;
    logic [PRICE_W-1:0] ask_price_reg, ask_price_next;
    logic [QTY_W-1:0]   ask_qty_reg, ask_qty_next;
    logic [QTY_W-1:0]   liq_reg, liq_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         out_status_reg;
    logic [QTY_W-1:0]   out_filled_reg;
    logic               out_bid_reg, out_ask_reg;
    logic [PRICE_W-1:0] out_bid_price_reg, out_ask_price_reg, out_mid_reg;
    logic [QTY_W-1:0]   out_bid_qty_reg, out_ask_qty_reg;
    logic signed [PRICE_W:0] out_spread_reg;

    logic               accept;
    logic               scan_end;
    logic               data_ok;
    logic [SLOT_W-1:0]  didx;
    entry_t             e;
    logic               passive;
    logic               price_ok;
    logic               take_go;
    logic [QTY_W-1:0]   take;
    logic [QTY_W-1:0]   left;
    logic [QTY_W-1:0]   new_qty;
    logic               out_free;
    logic               load_out;
    logic [PRICE_W:0]   mid_sum;

    assign accept   = req.valid && req.ready;
    assign scan_end = (cnt_reg == CNT_W'(ORDER_SLOTS));
    assign data_ok  = (cnt_reg != '0) && rd.valid;
    assign didx     = SLOT_W'(cnt_reg - 1'b1);
    assign e        = rd.data;
    assign passive  = ~side_reg;
    assign price_ok = passive ? (best_price_reg <= price_reg) : (best_price_reg >= price_reg);
    assign take_go  = best_found_reg && price_ok;
    assign take     = (best_qty_reg < remaining_reg) ? best_qty_reg : remaining_reg;
    assign left     = remaining_reg - take;
    assign new_qty  = best_qty_reg - take;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign load_out = (state_reg == S_DONE) && out_free;
    assign mid_sum  = {1'b0, bid_price_reg} + {1'b0, ask_price_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    priority if (req.command == CMD_ADD || req.command == CMD_MODIFY ||
                                 req.command == CMD_DELETE)
                        state_next = S_FIND;
                    else if (req.command == CMD_TRADE && req.quantity != '0)
                        state_next = S_BEST;
                    else
                        state_next = S_TOP;
                end
            end
            S_FIND:  if (scan_end) state_next = S_APPLY;
            S_APPLY: state_next = S_TOP;
            S_BEST:  if (scan_end) state_next = S_TAKE;
            S_TAKE:  state_next = (take_go && left != '0) ? S_BEST : S_TOP;
            S_TOP:   if (scan_end) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready     = (state_reg == S_IDLE);
        ctl           = '0;
        ctl.rd_addr   = cnt_reg[SLOT_W-1:0];
        ctl.wr_data   = '{side: side_reg, price: price_reg, key: key_reg, qty: qty_reg};
        unique case (state_reg)
            S_APPLY:
            begin
                priority if (cmd_reg == CMD_ADD)
                begin
                    if (hit_reg)
                    begin
                        ctl.wr_en       = 1'b1;
                        ctl.wr_addr     = hit_idx_reg;
                        ctl.wr_data.qty = sat_add(hit_qty_reg, qty_reg);
                    end
                    else if (qty_reg != '0 && free_reg)
                    begin
                        ctl.wr_en     = 1'b1;
                        ctl.set_valid = 1'b1;
                        ctl.wr_addr   = free_idx_reg;
                    end
                end
                else if (hit_reg)
                begin
                    ctl.wr_addr = hit_idx_reg;
                    if (cmd_reg == CMD_MODIFY && qty_reg != '0)
                        ctl.wr_en = 1'b1;
                    else
                        ctl.clr_valid = 1'b1;
                end
            end
            S_TAKE:
            begin
                if (take_go)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_addr   = best_idx_reg;
                    ctl.wr_data   = '{side: passive, price: best_price_reg,
                                      key: best_key_reg, qty: new_qty};
                    ctl.clr_valid = (new_qty == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = '0;
        cmd_next        = cmd_reg;
        side_next       = side_reg;
        price_next      = price_reg;
        key_next        = key_reg;
        qty_next        = qty_reg;
        remaining_next  = remaining_reg;
        status_next     = status_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_qty_next    = hit_qty_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_price_next = best_price_reg;
        best_key_next   = best_key_reg;
        best_qty_next   = best_qty_reg;
        bid_found_next  = bid_found_reg;
        bid_price_next  = bid_price_reg;
        bid_qty_next    = bid_qty_reg;
        ask_found_next  = ask_found_reg;
        ask_price_next  = ask_price_reg;
        ask_qty_next    = ask_qty_reg;
        liq_next        = liq_reg;

        if (state_reg == S_FIND || state_reg == S_BEST || state_reg == S_TOP)
            cnt_next = scan_end ? '0 : cnt_reg + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = req.command;
                    side_next       = req.side;
                    price_next      = req.price;
                    key_next        = req.order_key;
                    qty_next        = req.quantity;
                    remaining_next  = req.quantity;
                    status_next     = STATUS_OK;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    best_found_next = 1'b0;
                    bid_found_next  = 1'b0;
                    bid_price_next  = '0;
                    bid_qty_next    = '0;
                    ask_found_next  = 1'b0;
                    ask_price_next  = '0;
                    ask_qty_next    = '0;
                    liq_next        = '0;
                end
            end
            S_FIND:
            begin
                if (data_ok && !hit_reg && e.side == side_reg && e.price == price_reg &&
                    e.key == key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = didx;
                    hit_qty_next = e.qty;
                end
                if (cnt_reg != '0 && !rd.valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = didx;
                end
            end
            S_APPLY:
            begin
                priority if (cmd_reg == CMD_ADD)
                begin
                    if (!hit_reg && qty_reg != '0 && !free_reg)
                        status_next = STATUS_FULL;
                end
                else if (!hit_reg)
                    status_next = STATUS_NOT_FOUND;
            end
            S_BEST:
            begin
                if (data_ok && e.side == passive)
                begin
                    if (!best_found_reg ||
                        (passive ? (e.price < best_price_reg) : (e.price > best_price_reg)) ||
                        (e.price == best_price_reg && e.key < best_key_reg))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = didx;
                        best_price_next = e.price;
                        best_key_next   = e.key;
                        best_qty_next   = e.qty;
                    end
                end
            end
            S_TAKE:
            begin
                if (take_go)
                    remaining_next = left;
                best_found_next = 1'b0;
            end
            S_TOP:
            begin
                if (data_ok)
                begin
                    if (e.side == SIDE_BUY)
                    begin
                        priority if (!bid_found_reg || e.price > bid_price_reg)
                        begin
                            bid_found_next = 1'b1;
                            bid_price_next = e.price;
                            bid_qty_next   = e.qty;
                        end
                        else if (e.price == bid_price_reg)
                            bid_qty_next = sat_add(bid_qty_reg, e.qty);
                    end
                    else
                    begin
                        priority if (!ask_found_reg || e.price < ask_price_reg)
                        begin
                            ask_found_next = 1'b1;
                            ask_price_next = e.price;
                            ask_qty_next   = e.qty;
                        end
                        else if (e.price == ask_price_reg)
                            ask_qty_next = sat_add(ask_qty_reg, e.qty);
                    end
                    if (cmd_reg == CMD_QUERY && e.side == passive &&
                        (passive ? (e.price <= price_reg) : (e.price >= price_reg)))
                        liq_next = sat_add(liq_reg, e.qty);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
            rsp_valid_next = 1'b0;
        if (load_out)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        side_reg       <= side_next;
        price_reg      <= price_next;
        key_reg        <= key_next;
        qty_reg        <= qty_next;
        remaining_reg  <= remaining_next;
        status_reg     <= status_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_qty_reg    <= hit_qty_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_price_reg <= best_price_next;
        best_key_reg   <= best_key_next;
        best_qty_reg   <= best_qty_next;
        bid_found_reg  <= bid_found_next;
        bid_price_reg  <= bid_price_next;
        bid_qty_reg    <= bid_qty_next;
        ask_found_reg  <= ask_found_next;
        ask_price_reg  <= ask_price_next;
        ask_qty_reg    <= ask_qty_next;
        liq_reg        <= liq_next;
        if (load_out)
        begin
            out_status_reg    <= status_reg;
            out_filled_reg    <= (cmd_reg == CMD_TRADE) ? qty_reg - remaining_reg :
                                 (cmd_reg == CMD_QUERY) ? liq_reg : '0;
            out_bid_reg       <= bid_found_reg;
            out_bid_price_reg <= bid_price_reg;
            out_bid_qty_reg   <= bid_qty_reg;
            out_ask_reg       <= ask_found_reg;
            out_ask_price_reg <= ask_price_reg;
            out_ask_qty_reg   <= ask_qty_reg;
            out_mid_reg       <= (bid_found_reg && ask_found_reg) ? mid_sum[PRICE_W:1] : '0;
            out_spread_reg    <= (bid_found_reg && ask_found_reg) ?
                                 $signed({1'b0, ask_price_reg} - {1'b0, bid_price_reg}) : '0;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.filled_qty     = out_filled_reg;
    assign rsp.bid_present    = out_bid_reg;
    assign rsp.best_bid_price = out_bid_price_reg;
    assign rsp.best_bid_qty   = out_bid_qty_reg;
    assign rsp.ask_present    = out_ask_reg;
    assign rsp.best_ask_price = out_ask_price_reg;
    assign rsp.best_ask_qty   = out_ask_qty_reg;
    assign rsp.midpoint       = out_mid_reg;
    assign rsp.spread         = out_spread_reg;

    a_take_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAKE |-> remaining_reg != '0)
        else $error("fill step entered with nothing left to fill");

    a_set_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.set_valid |-> (!hit_reg && free_reg && state_reg == S_APPLY))
        else $error("new order placed without a free slot");

    a_clr_on_full_take: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.clr_valid && state_reg == S_TAKE) |-> best_qty_reg <= remaining_reg)
        else $error("order removed before it was fully consumed");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("finished request did not produce a response");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ORDER_SLOTS))
        else $error("scan counter out of range");

endmodule

// ===== rtl/limit_order_book.sv =====
`timescale 1ns / 1ps

// Limit order book with up to ORDER_SLOTS (256) resting orders kept in a table with one
// read and one write port. Every request is handled by a sequencer that sweeps the table
// one entry per cycle through one compare/accumulate unit, so a request takes whole passes
// over the table. A query or an unknown command makes a top-of-book pass; add, modify and
// delete make a search pass, a write step and a top-of-book pass; a nonzero trade repeats a
// best-order pass and a fill step while orders match and quantity remains, then a top pass.
// The table read port is registered. The block takes one request at a time and
// holds ready low until its response is loaded into the output register; a response
// waiting there does not block the next request.
module limit_order_book (
    input logic       clk,
    input logic       rst_n,
    lob_req_if.sink   req,
    lob_rsp_if.source rsp
);
    import lob_pkg::*;

    store_ctl_t ctl;
    store_rd_t  rd;

    lob_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .rd    (rd)
    );

    lob_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rd    (rd)
    );

endmodule

// ===== sim/limit_order_book_tb.sv =====
`timescale 1ns / 1ps

module limit_order_book_tb;
    import lob_pkg::*;

    localparam int IDLE_LIMIT = 400000;
    localparam int KEY_SPAN   = 8;
    localparam logic [2:0] CMD_RESERVED = 3'd5;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] filled_qty;
        logic        bid_present;
        logic [31:0] best_bid_price;
        logic [31:0] best_bid_qty;
        logic        ask_present;
        logic [31:0] best_ask_price;
        logic [31:0] best_ask_qty;
        logic [31:0] midpoint;
        logic [32:0] spread;
    } book_snapshot_t;

    logic clk;
    logic rst_n;

    lob_req_if req ();
    lob_rsp_if rsp ();

    limit_order_book u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bit          book_valid [ORDER_SLOTS];
    logic        book_side  [ORDER_SLOTS];
    logic [31:0] book_price [ORDER_SLOTS];
    logic [31:0] book_key   [ORDER_SLOTS];
    logic [31:0] book_qty   [ORDER_SLOTS];

    book_snapshot_t pending_snapshots [$];

    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int requests_sent = 0;
    int responses_seen = 0;
    int trades_sent = 0;
    int fills_seen = 0;
    int full_seen = 0;
    int stall_phase = 0;
    bit stall_on = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] qty_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int locate_order(logic sd, logic [31:0] pr, logic [31:0] k);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (book_valid[i] && book_side[i] == sd && book_price[i] == pr && book_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int best_resting(logic sd);
        int b;
        b = -1;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            if (!book_valid[i] || book_side[i] != sd)
                continue;
            if (b < 0)
                b = i;
            else if ((sd ? book_price[i] < book_price[b] : book_price[i] > book_price[b]) ||
                     (book_price[i] == book_price[b] && book_key[i] < book_key[b]))
                b = i;
        end
        return b;
    endfunction

    function automatic void top_level(logic sd, output bit found,
                                      output logic [31:0] pr, output logic [31:0] q);
        found = 0;
        pr = '0;
        q = '0;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            if (!book_valid[i] || book_side[i] != sd)
                continue;
            if (!found || (sd ? book_price[i] < pr : book_price[i] > pr))
            begin
                found = 1;
                pr = book_price[i];
                q = book_qty[i];
            end
            else if (book_price[i] == pr)
                q = qty_sum(q, book_qty[i]);
        end
    endfunction

    function automatic book_snapshot_t apply_request(logic [2:0] cmd, logic sd,
                                                     logic [31:0] pr, logic [31:0] k,
                                                     logic [31:0] q);
        book_snapshot_t r;
        int s;
        int b;
        logic [31:0] remaining;
        logic [31:0] take;
        bit hb;
        bit ha;
        r = '0;
        case (cmd)
            CMD_ADD:
            begin
                s = locate_order(sd, pr, k);
                if (s >= 0)
                    book_qty[s] = qty_sum(book_qty[s], q);
                else if (q != 0)
                begin
                    s = -1;
                    for (int i = 0; i < ORDER_SLOTS; i++)
                        if (!book_valid[i] && s < 0)
                            s = i;
                    if (s < 0)
                        r.status = STATUS_FULL;
                    else
                    begin
                        book_valid[s] = 1;
                        book_side[s] = sd;
                        book_price[s] = pr;
                        book_key[s] = k;
                        book_qty[s] = q;
                    end
                end
            end
            CMD_MODIFY, CMD_DELETE:
            begin
                s = locate_order(sd, pr, k);
                if (s < 0)
                    r.status = STATUS_NOT_FOUND;
                else if (cmd == CMD_MODIFY && q != 0)
                    book_qty[s] = q;
                else
                    book_valid[s] = 0;
            end
            CMD_TRADE:
            begin
                remaining = q;
                for (int n = 0; n <= ORDER_SLOTS && remaining > 0; n++)
                begin
                    b = best_resting(~sd);
                    if (b < 0)
                        break;
                    if (~sd ? book_price[b] > pr : book_price[b] < pr)
                        break;
                    take = book_qty[b] < remaining ? book_qty[b] : remaining;
                    book_qty[b] -= take;
                    remaining -= take;
                    if (book_qty[b] == 0)
                        book_valid[b] = 0;
                end
                r.filled_qty = q - remaining;
            end
            CMD_QUERY:
            begin
                for (int i = 0; i < ORDER_SLOTS; i++)
                    if (book_valid[i] && book_side[i] == ~sd &&
                        (~sd ? book_price[i] <= pr : book_price[i] >= pr))
                        r.filled_qty = qty_sum(r.filled_qty, book_qty[i]);
            end
            default: ;
        endcase
        top_level(SIDE_BUY, hb, r.best_bid_price, r.best_bid_qty);
        top_level(SIDE_SELL, ha, r.best_ask_price, r.best_ask_qty);
        r.bid_present = hb;
        r.ask_present = ha;
        if (hb && ha)
        begin
            r.midpoint = 32'(({1'b0, r.best_bid_price} + {1'b0, r.best_ask_price}) >> 1);
            r.spread = {1'b0, r.best_ask_price} - {1'b0, r.best_bid_price};
        end
        return r;
    endfunction

    task automatic send_request(logic [2:0] cmd, logic sd, logic [31:0] pr,
                                logic [31:0] k, logic [31:0] q);
        book_snapshot_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        req.valid     <= 1'b1;
        req.command   <= cmd;
        req.side      <= sd;
        req.price     <= pr;
        req.order_key <= k;
        req.quantity  <= q;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        r = apply_request(cmd, sd, pr, k, q);
        pending_snapshots.insert(pending_snapshots.size(), r);
        requests_sent++;
        if (cmd == CMD_TRADE)
            trades_sent++;
        if (r.status == STATUS_FULL)
            full_seen++;
        if (cmd == CMD_TRADE && r.filled_qty != 0)
            fills_seen++;
    endtask

    task automatic check_field(string name, logic [32:0] exp_v, logic [32:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        book_snapshot_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            responses_seen++;
            if (pending_snapshots.size() == 0)
            begin
                errors++;
                $display("%0t: response with nothing expected, expected none, actual status %0h",
                         $realtime, rsp.status);
            end
            else
            begin
                e = pending_snapshots.pop_front();
                check_field("status", e.status, rsp.status);
                check_field("filled_qty", e.filled_qty, rsp.filled_qty);
                check_field("bid_present", e.bid_present, rsp.bid_present);
                check_field("best_bid_price", e.best_bid_price, rsp.best_bid_price);
                check_field("best_bid_qty", e.best_bid_qty, rsp.best_bid_qty);
                check_field("ask_present", e.ask_present, rsp.ask_present);
                check_field("best_ask_price", e.best_ask_price, rsp.best_ask_price);
                check_field("best_ask_qty", e.best_ask_qty, rsp.best_ask_qty);
                check_field("midpoint", e.midpoint, rsp.midpoint);
                check_field("spread", e.spread, rsp.spread);
            end
        end
    end

    always @(posedge clk)
    begin
        stall_phase++;
        if (stall_phase >= 700)
        begin
            stall_phase = 0;
            stall_on = $urandom_range(0, 2) != 0;
        end
        rsp.ready <= stall_on ? ($urandom_range(0, 4) > 1) : 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $realtime, pending_snapshots.size());
            $display("limit_order_book_tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(CMD_QUERY, SIDE_BUY, 32'hFFFF_FFFF, 0, 0);
        send_request(CMD_TRADE, SIDE_BUY, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        send_request(CMD_ADD, SIDE_BUY, 0, 0, 1);
        send_request(CMD_ADD, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_ADD, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5);
        send_request(CMD_ADD, SIDE_SELL, 32'hFFFF_FFFF, 7, 32'hFFFF_FFF0);
        send_request(CMD_ADD, SIDE_BUY, 500, 3, 0);
        send_request(CMD_MODIFY, SIDE_BUY, 500, 3, 10);
        send_request(CMD_DELETE, SIDE_SELL, 1, 1, 1);
        send_request(CMD_ADD, SIDE_BUY, 100, 2, 40);
        send_request(CMD_ADD, SIDE_BUY, 100, 1, 30);
        send_request(CMD_ADD, SIDE_SELL, 50, 9, 25);
        send_request(CMD_MODIFY, SIDE_BUY, 100, 2, 60);
        send_request(CMD_QUERY, SIDE_SELL, 90, 0, 0);
        send_request(CMD_QUERY, SIDE_BUY, 32'hFFFF_FFFF, 0, 0);
        send_request(CMD_TRADE, SIDE_SELL, 200, 0, 10);
        send_request(CMD_TRADE, SIDE_SELL, 100, 0, 45);
        send_request(CMD_TRADE, SIDE_BUY, 50, 0, 100);
        send_request(CMD_RESERVED, SIDE_BUY, 0, 0, 0);
    endtask

    task automatic test_fill_table();
        logic        sd;
        logic [31:0] pr;
        for (int i = 0; i < ORDER_SLOTS + 4; i++)
        begin
            sd = i[0];
            pr = sd ? 32'(2000 + i) : 32'(10 + i);
            send_request(CMD_ADD, sd, pr, 32'(i), 32'(i + 1));
        end
    endtask

    task automatic test_sweep();
        send_request(CMD_QUERY, SIDE_BUY, 32'hFFFF_FFFF, 0, 0);
        send_request(CMD_TRADE, SIDE_BUY, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        send_request(CMD_TRADE, SIDE_SELL, 100, 0, 1000);
    endtask

    task automatic test_random(int count);
        logic [2:0]  cmd;
        logic        sd;
        logic [31:0] pr;
        logic [31:0] k;
        logic [31:0] q;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = CMD_ADD;
            else if (pick < 52)
                cmd = CMD_MODIFY;
            else if (pick < 64)
                cmd = CMD_DELETE;
            else if (pick < 84)
                cmd = CMD_TRADE;
            else if (pick < 96)
                cmd = CMD_QUERY;
            else
                cmd = CMD_RESERVED;
            sd = 1'($urandom_range(0, 1));
            pr = 32'($urandom_range(95, 105));
            k  = 32'($urandom_range(0, KEY_SPAN - 1));
            q  = ($urandom_range(0, 24) == 0) ? 32'hFFFF_FF00 : 32'($urandom_range(0, 60));
            send_request(cmd, sd, pr, k, q);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid <= 1'b0;
        req.command <= CMD_ADD;
        req.side <= SIDE_BUY;
        req.price <= '0;
        req.order_key <= '0;
        req.quantity <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_table();
        test_sweep();
        test_random(768);
        req.valid <= 1'b0;
        while (responses_seen < requests_sent)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (pending_snapshots.size() != 0)
        begin
            errors++;
            $display("%0t: responses missing, expected %0d, actual %0d",
                     $realtime, requests_sent, responses_seen);
        end
        $display("covered %0d requests with %0d responses, %0d trades of which %0d filled,",
                 requests_sent, responses_seen, trades_sent, fills_seen);
        $display("%0d adds refused on a full table, under random gaps and output stalls",
                 full_seen);
        if (errors == 0)
            $display("limit_order_book_tb: done, clean");
        else
            $display("limit_order_book_tb: done, errors");
        $finish;
    end

endmodule
